FILE: hw/rtl/kaf_pkg.sv
package kaf_pkg;

  // Fraction bits of the time step and of the covariance, gain and noise terms
  localparam int unsigned DT_FRAC_BITS  = 16;
  localparam int unsigned COV_FRAC_BITS = 24;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE_ANGLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE_BIAS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE       = 2'd2;

  localparam logic [31:0] PROC_NOISE_ANGLE_RST = 32'd16777;
  localparam logic [31:0] PROC_NOISE_BIAS_RST  = 32'd50332;
  localparam logic [31:0] MEAS_NOISE_RST       = 32'd503316;

  // Beat widths
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic [32:0]        den;
  } kaf_div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] gain;
  } kaf_div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
    logic signed [31:0] r;
    if (v > 56'sd2147483647) begin
      r = SAT_MAX;
    end else if (v < -56'sd2147483648) begin
      r = SAT_MIN;
    end else begin
      r = $signed(v[31:0]);
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/kalman_angle_filter_unit.sv
// Channel  Dir  Width  Contents (lowest bit up)
// in_      in   80     measured_angle[31:0], measured_rate[63:32], time_step[79:64]
// out_     out  32     filtered_angle[31:0]
// cfg_     in   2/32   register index, write data; no read-back
//
// A beat runs through the sequencer from accept to result, and the next beat can be taken in
// the cycle after the result. The two gain divisions dominate, each a start, 32 quotient bits
// in the bit-serial divider and a done. The ten products go through the shared multiplier,
// each as a multiply state then an accumulate state. The divisions are skipped when the
// innovation variance is not positive.
// Input is taken only while the sequencer is idle; the finished angle waits in
// the output register, so a stalled output holds only the next completion.
// Reset (synchronous, active low) clears state, covariance and loads noise defaults.
module kalman_angle_filter_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // measured_angle[31:0], measured_rate[63:32], time_step[79:64]
  input  logic [kaf_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // filtered_angle[31:0]
  output logic [kaf_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_we,
  input  logic [kaf_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [kaf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import kaf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ACC, S_SETUP, S_GAIN, S_DIV, S_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_RATE, OP_DP11, OP_P00, OP_P11N,
    OP_ANG, OP_BIAS, OP_P10C, OP_P11C, OP_P00C, OP_P01C
  } op_t;

  state_t state_r;
  op_t    op_r;
  logic   gsel_r;
  logic   out_valid_r;
  logic [31:0] out_data_r;

  logic [31:0] qa_r, qb_r, rn_r;
  logic signed [31:0] ang_r, bias_r, p00_r, p01_r, p10_r, p11_r;

  logic signed [31:0] meas_r, rate_r, y_r, k0_r, k1_r;
  logic [15:0]        dt_r;
  logic signed [32:0] dp11_r;
  logic signed [35:0] inner_r;
  logic signed [33:0] s_r;
  logic signed [67:0] prod_r;

  logic signed [31:0] in_angle, in_rate;
  logic signed [31:0] mul_a;
  logic signed [35:0] mul_b;
  logic               use24;
  logic signed [67:0] prod_h, prod_s;
  logic signed [51:0] rnd;
  logic signed [31:0] acc_base;
  logic               acc_neg;
  logic signed [55:0] acc_sum;
  logic signed [31:0] acc_val;
  logic               s_pos;

  kaf_div_req_t div_req;
  kaf_div_rsp_t div_rsp;

  assign in_angle  = $signed(in_tdata[31:0]);
  assign in_rate   = $signed(in_tdata[63:32]);
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign s_pos = !s_r[33] && (s_r != 34'sd0);

  assign div_req.start = (state_r == S_GAIN) && s_pos;
  assign div_req.num   = gsel_r ? p10_r : p00_r;
  assign div_req.den   = s_r[32:0];

  kaf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = $signed({16'd0, dt_r});
    mul_b = 36'(rate_r);
    case (op_r)
      OP_RATE: mul_b = 36'(rate_r);
      OP_DP11: mul_b = 36'(p11_r);
      OP_P00:  mul_b = inner_r;
      OP_P11N: mul_b = $signed({4'd0, qb_r});
      OP_ANG: begin
        mul_a = k0_r;
        mul_b = 36'(y_r);
      end
      OP_BIAS: begin
        mul_a = k1_r;
        mul_b = 36'(y_r);
      end
      OP_P10C: begin
        mul_a = k1_r;
        mul_b = 36'(p00_r);
      end
      OP_P11C: begin
        mul_a = k1_r;
        mul_b = 36'(p01_r);
      end
      OP_P00C: begin
        mul_a = k0_r;
        mul_b = 36'(p00_r);
      end
      OP_P01C: begin
        mul_a = k0_r;
        mul_b = 36'(p01_r);
      end
      default: mul_b = 36'(rate_r);
    endcase
  end

  // Round to nearest, ties up, then accumulate and saturate
  always_comb begin
    use24  = (op_r >= OP_ANG);
    prod_h = prod_r + (use24 ? (68'sd1 <<< (COV_FRAC_BITS - 1))
                             : (68'sd1 <<< (DT_FRAC_BITS - 1)));
    prod_s = use24 ? (prod_h >>> COV_FRAC_BITS) : (prod_h >>> DT_FRAC_BITS);
    rnd    = $signed(prod_s[51:0]);
    acc_neg = 1'b0;
    case (op_r)
      OP_RATE, OP_ANG: acc_base = ang_r;
      OP_P00:          acc_base = p00_r;
      OP_P11N:         acc_base = p11_r;
      OP_BIAS:         acc_base = bias_r;
      OP_P10C: begin
        acc_base = p10_r;
        acc_neg  = 1'b1;
      end
      OP_P11C: begin
        acc_base = p11_r;
        acc_neg  = 1'b1;
      end
      OP_P00C: begin
        acc_base = p00_r;
        acc_neg  = 1'b1;
      end
      OP_P01C: begin
        acc_base = p01_r;
        acc_neg  = 1'b1;
      end
      default: acc_base = 32'sd0;
    endcase
    acc_sum = acc_neg ? (56'(acc_base) - 56'(rnd)) : (56'(acc_base) + 56'(rnd));
    acc_val = sat32(acc_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_RATE;
      gsel_r      <= 1'b0;
      out_valid_r <= 1'b0;
      qa_r        <= PROC_NOISE_ANGLE_RST;
      qb_r        <= PROC_NOISE_BIAS_RST;
      rn_r        <= MEAS_NOISE_RST;
      ang_r       <= '0;
      bias_r      <= '0;
      p00_r       <= '0;
      p01_r       <= '0;
      p10_r       <= '0;
      p11_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_PROC_NOISE_ANGLE: qa_r <= cfg_wdata;
          CFG_PROC_NOISE_BIAS:  qb_r <= cfg_wdata;
          CFG_MEAS_NOISE:       rn_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_valid_r && out_tready && (state_r != S_FINISH)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            meas_r  <= in_angle;
            dt_r    <= in_tdata[79:64];
            rate_r  <= sat32(56'(in_rate) - 56'(bias_r));
            op_r    <= OP_RATE;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= mul_a * mul_b;
          state_r <= S_ACC;
        end
        S_ACC: begin
          case (op_r)
            OP_RATE, OP_ANG: ang_r <= acc_val;
            OP_DP11: begin
              dp11_r  <= rnd[32:0];
              inner_r <= $signed(rnd[35:0]) - 36'(p01_r) - 36'(p10_r)
                         + $signed({4'd0, qa_r});
            end
            OP_P00: begin
              p00_r <= acc_val;
              p01_r <= sat32(56'(p01_r) - 56'(dp11_r));
              p10_r <= sat32(56'(p10_r) - 56'(dp11_r));
            end
            OP_P11N, OP_P11C: p11_r  <= acc_val;
            OP_BIAS:          bias_r <= acc_val;
            OP_P10C:          p10_r  <= acc_val;
            OP_P00C:          p00_r  <= acc_val;
            OP_P01C:          p01_r  <= acc_val;
            default: ;
          endcase
          if (op_r == OP_P11N) begin
            state_r <= S_SETUP;
          end else if (op_r == OP_P01C) begin
            state_r <= S_FINISH;
          end else begin
            op_r    <= op_t'(op_r + 4'd1);
            state_r <= S_MUL;
          end
        end
        S_SETUP: begin
          s_r     <= 34'(p00_r) + $signed({2'd0, rn_r});
          y_r     <= sat32(56'(meas_r) - 56'(ang_r));
          gsel_r  <= 1'b0;
          state_r <= S_GAIN;
        end
        S_GAIN: begin
          if (s_pos) begin
            state_r <= S_DIV;
          end else begin
            // no correction: zero gains leave estimate and covariance as predicted
            k0_r    <= '0;
            k1_r    <= '0;
            op_r    <= OP_ANG;
            state_r <= S_MUL;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            if (!gsel_r) begin
              k0_r    <= div_rsp.gain;
              gsel_r  <= 1'b1;
              state_r <= S_GAIN;
            end else begin
              k1_r    <= div_rsp.gain;
              op_r    <= OP_ANG;
              state_r <= S_MUL;
            end
          end
        end
        S_FINISH: begin
          // hold until the previous beat has left the output register
          if (!out_valid_r || out_tready) begin
            out_data_r  <= ang_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/kaf_div.sv
module kaf_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  kaf_pkg::kaf_div_req_t req,
  output kaf_pkg::kaf_div_rsp_t rsp
);
  import kaf_pkg::*;

  // Restoring long division of |num| * 2^24 + den/2 by den, one quotient bit per cycle.
  logic [31:0] mag;
  logic [55:0] numer;
  logic [33:0] trial;
  logic        fits;

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic        neg_r;
  logic        ovf_r;
  logic [32:0] den_r;
  logic [32:0] rem_r;
  logic [31:0] nlow_r;
  logic [31:0] quo_r;

  assign mag   = req.num[31] ? 32'(-req.num) : req.num;
  assign numer = {mag, 24'd0} + 56'(req.den >> 1);
  assign trial = {rem_r, nlow_r[31]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        neg_r  <= req.num[31];
        den_r  <= req.den;
        ovf_r  <= {9'd0, numer[55:32]} >= req.den;
        rem_r  <= {9'd0, numer[55:32]};
        nlow_r <= numer[31:0];
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r  <= fits ? 33'(trial - {1'b0, den_r}) : trial[32:0];
        quo_r  <= {quo_r[30:0], fits};
        nlow_r <= {nlow_r[30:0], 1'b0};
        cnt_r  <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Saturate: any quotient of 2^31 or more clips to the rail of its sign
  always_comb begin
    rsp.done = done_r;
    if (ovf_r || quo_r[31]) begin
      rsp.gain = neg_r ? SAT_MIN : SAT_MAX;
    end else begin
      rsp.gain = neg_r ? -$signed(quo_r) : $signed(quo_r);
    end
  end

endmodule
